### hw/rtl/ecsm_pkg.sv
package ecsm_pkg;

    localparam int FIELD_BITS = 8;
    localparam int PROD_BITS  = 2 * FIELD_BITS;
    localparam int EXP_BITS   = FIELD_BITS;
    localparam int SCL_BITS   = 8;
    localparam logic [FIELD_BITS-1:0] MOD_RESET = FIELD_BITS'(223);
    localparam logic [FIELD_BITS-1:0] MOD_MIN   = FIELD_BITS'(3);

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;  // latch reduced base, acc := base or zero
    localparam logic [3:0] OP_SLOPE   = 4'd2;  // form numerator and denominator
    localparam logic [3:0] OP_INV_INI = 4'd3;  // r := 1, b := den, e := p-2
    localparam logic [3:0] OP_INV_STP = 4'd4;  // one square-and-multiply step
    localparam logic [3:0] OP_LAMBDA  = 4'd5;  // lam := num * inv
    localparam logic [3:0] OP_X3      = 4'd6;
    localparam logic [3:0] OP_Y3      = 4'd7;
    localparam logic [3:0] OP_RED     = 4'd8;  // reduce inputs by one subtract step

    typedef struct packed {
        logic [3:0] op;
        logic       mul_go;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic exp_done;
        logic red_done;
    } dp_stat_t;

endpackage

### hw/rtl/ecsm_modmul.sv
module ecsm_modmul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] a,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] b,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] p,
    output logic                          busy,
    output logic [ecsm_pkg::FIELD_BITS-1:0] prod
);
    import ecsm_pkg::*;

    // Shift-and-add modular multiply, one bit of b per cycle, MSB first.
    localparam int CNT_BITS = $clog2(FIELD_BITS + 1);

    logic [FIELD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_BITS-1:0] a_reg, a_next;
    logic [FIELD_BITS-1:0] b_reg, b_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [FIELD_BITS+1:0] dbl, dbl_r, add, add_r;

    always_comb
    begin
        dbl = {2'b0, acc_reg} << 1;
        dbl_r = (dbl >= {2'b0, p}) ? dbl - {2'b0, p} : dbl;
        add = dbl_r + (b_reg[FIELD_BITS-1] ? {2'b0, a_reg} : '0);
        add_r = (add >= {2'b0, p}) ? add - {2'b0, p} : add;
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        if (go)
        begin
            acc_next = '0;
            a_next = a;
            b_next = b;
            cnt_next = CNT_BITS'(FIELD_BITS);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = add_r[FIELD_BITS-1:0];
            b_next = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;
endmodule

### hw/rtl/ecsm_datapath.sv
module ecsm_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ecsm_pkg::dp_cmd_t               cmd,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] p,
    input  logic [7:0]                      in_x,
    input  logic [7:0]                      in_y,
    input  logic                            zero_scalar,
    output ecsm_pkg::dp_stat_t              stat,
    output logic [ecsm_pkg::FIELD_BITS-1:0] acc_x,
    output logic [ecsm_pkg::FIELD_BITS-1:0] acc_y
);
    import ecsm_pkg::*;

    logic [FIELD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [FIELD_BITS-1:0] num_reg, den_reg, lam_reg, x3_reg;
    logic [FIELD_BITS-1:0] r_reg, b_reg, e_reg;
    logic                  dbl_reg, mul_phase_reg;
    logic [7:0]            rx_reg, ry_reg;
    logic [FIELD_BITS-1:0] ma, mb, mprod;
    logic                  mbusy;

    // Modular add/sub helpers on reduced operands.
    function automatic logic [FIELD_BITS-1:0] msub(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS:0] d;
        d = {1'b0, a} + {1'b0, m} - {1'b0, b};
        return (d >= {1'b0, m}) ? FIELD_BITS'(d - {1'b0, m}) : d[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] madd(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? FIELD_BITS'(s - {1'b0, m}) : s[FIELD_BITS-1:0];
    endfunction

    ecsm_modmul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (ma),
        .b     (mb),
        .p     (p),
        .busy  (mbusy),
        .prod  (mprod)
    );

    // Operand selection follows the op being started.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_SLOPE:
            begin
                ma = ax_reg;
                mb = ax_reg;
            end
            OP_INV_STP:
            begin
                ma = mul_phase_reg ? b_reg : r_reg;
                mb = b_reg;
            end
            OP_LAMBDA:
            begin
                ma = num_reg;
                mb = r_reg;
            end
            OP_X3:
            begin
                ma = lam_reg;
                mb = lam_reg;
            end
            OP_Y3:
            begin
                ma = lam_reg;
                mb = msub(ax_reg, x3_reg, p);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // For the multiplying ops, a command without mul_go is the completion step of the same op code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            num_reg <= '0;
            den_reg <= '0;
            lam_reg <= '0;
            x3_reg <= '0;
            r_reg <= '0;
            b_reg <= '0;
            e_reg <= '0;
            dbl_reg <= 1'b0;
            rx_reg <= '0;
            ry_reg <= '0;
            mul_phase_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_RED:
                begin
                    if (cmd.mul_go)
                    begin
                        rx_reg <= in_x;
                        ry_reg <= in_y;
                    end
                    else
                    begin
                        if ({1'b0, rx_reg} >= 9'(p)) rx_reg <= rx_reg - 8'(p);
                        if ({1'b0, ry_reg} >= 9'(p)) ry_reg <= ry_reg - 8'(p);
                    end
                end
                OP_LOAD:
                begin
                    bx_reg <= FIELD_BITS'(rx_reg);
                    by_reg <= FIELD_BITS'(ry_reg);
                    ax_reg <= zero_scalar ? '0 : FIELD_BITS'(rx_reg);
                    ay_reg <= zero_scalar ? '0 : FIELD_BITS'(ry_reg);
                end
                OP_SLOPE:
                begin
                    if (cmd.mul_go)
                    begin
                        dbl_reg <= (ax_reg == bx_reg) && (ay_reg == by_reg);
                        num_reg <= msub(by_reg, ay_reg, p);
                        den_reg <= msub(bx_reg, ax_reg, p);
                    end
                    else if (dbl_reg)
                    begin
                        num_reg <= madd(madd(mprod, mprod, p), mprod, p);
                        den_reg <= madd(ay_reg, ay_reg, p);
                    end
                end
                OP_INV_INI:
                begin
                    r_reg <= FIELD_BITS'(1);
                    b_reg <= den_reg;
                    e_reg <= p - FIELD_BITS'(2);
                    mul_phase_reg <= 1'b0;
                end
                OP_INV_STP:
                begin
                    // Phase 0: r *= b if the exponent bit is set; phase 1: b := b*b.
                    if (!cmd.mul_go)
                    begin
                        if (!mul_phase_reg)
                        begin
                            if (e_reg[0]) r_reg <= mprod;
                        end
                        else
                        begin
                            b_reg <= mprod;
                            e_reg <= e_reg >> 1;
                        end
                        mul_phase_reg <= !mul_phase_reg;
                    end
                end
                OP_LAMBDA:
                begin
                    if (!cmd.mul_go) lam_reg <= mprod;
                end
                OP_X3:
                begin
                    if (!cmd.mul_go)
                        x3_reg <= dbl_reg ? msub(mprod, madd(ax_reg, ax_reg, p), p)
                                          : msub(msub(mprod, ax_reg, p), bx_reg, p);
                end
                OP_Y3:
                begin
                    if (!cmd.mul_go)
                    begin
                        ay_reg <= msub(mprod, ay_reg, p);
                        ax_reg <= x3_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.mul_busy = mbusy;
    assign stat.exp_done = (e_reg == '0) && !mul_phase_reg;
    assign stat.red_done = ({1'b0, rx_reg} < 9'(p)) && ({1'b0, ry_reg} < 9'(p));
    assign acc_x = ax_reg;
    assign acc_y = ay_reg;
endmodule

### hw/rtl/ecsm_ctrl.sv
module ecsm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [7:0]           scalar,
    input  ecsm_pkg::dp_stat_t   stat,
    output ecsm_pkg::dp_cmd_t    cmd,
    output logic                 zero_scalar,
    output logic                 busy,
    output logic                 done
);
    import ecsm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [3:0]          op_reg, op_next;
    logic [SCL_BITS-1:0] left_reg, left_next;
    logic                zero_reg, zero_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        left_next = left_reg;
        zero_next = zero_reg;
        cmd.op = OP_NONE;
        cmd.mul_go = 1'b0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_RED;
                    cmd.mul_go = 1'b1;
                    zero_next = (scalar == '0);
                    left_next = (scalar == '0) ? '0 : scalar - 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op = stat.red_done ? OP_LOAD : OP_RED;
                if (stat.red_done) state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (left_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    op_next = OP_SLOPE;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.op = op_reg;
                if (op_reg == OP_INV_INI)
                begin
                    op_next = OP_INV_STP;
                end
                else if (op_reg == OP_INV_STP && stat.exp_done)
                begin
                    op_next = OP_LAMBDA;
                end
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.mul_busy)
                begin
                    cmd.op = op_reg;
                    state_next = S_ISSUE;
                    case (op_reg)
                        OP_SLOPE:  op_next = OP_INV_INI;
                        OP_INV_STP: op_next = OP_INV_STP;
                        OP_LAMBDA: op_next = OP_X3;
                        OP_X3:     op_next = OP_Y3;
                        OP_Y3:
                        begin
                            left_next = left_reg - 1'b1;
                            state_next = S_CHECK;
                        end
                        default:   state_next = S_CHECK;
                    endcase
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_NONE;
            left_reg <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            left_reg <= left_next;
            zero_reg <= zero_next;
        end
    end

    assign zero_scalar = zero_reg;
    assign busy = (state_reg != S_IDLE);
endmodule

### hw/rtl/ecc_scalar_multiply_small_field.sv
// Channel   Handshake          Payload
// input     start, busy        point_x, point_y, scalar
// result    result_valid       result_x, result_y
// config    cfg_we             cfg_data (field modulus)
//
// Busy stays high from the taking of an item until the result is shown; its length grows with
// the scalar, with the bit length of p-2 and with the subtract steps that reduce the larger
// coordinate, and a scalar of zero takes as long as a scalar of one. The bit-serial modular
// multiplier, shared by the inverse, sets the length of each point addition.
// Reset clears the controller and the accumulator; the modulus resets to 223.
// The result is shown for one cycle; the receiver cannot stall it.
module ecc_scalar_multiply_small_field
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] point_x,
    input  logic [7:0] point_y,
    input  logic [7:0] scalar,
    output logic       result_valid,
    output logic [7:0] result_x,
    output logic [7:0] result_y
);
    import ecsm_pkg::*;

    logic [FIELD_BITS-1:0] mod_reg;
    logic [FIELD_BITS-1:0] p_eff;
    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic                  zero_scalar, done;
    logic [FIELD_BITS-1:0] ax, ay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MOD_RESET;
        else if (cfg_we)
            mod_reg <= cfg_data;
    end

    assign p_eff = (mod_reg < MOD_MIN) ? MOD_MIN : mod_reg;

    ecsm_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .scalar      (scalar),
        .stat        (stat),
        .cmd         (cmd),
        .zero_scalar (zero_scalar),
        .busy        (busy),
        .done        (done)
    );

    ecsm_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .p           (p_eff),
        .in_x        (point_x),
        .in_y        (point_y),
        .zero_scalar (zero_scalar),
        .stat        (stat),
        .acc_x       (ax),
        .acc_y       (ay)
    );

    assign result_valid = done;
    assign result_x = 8'(ax);
    assign result_y = 8'(ay);

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result without item in flight");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result strobe longer than one cycle");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ax < p_eff) && (ay < p_eff)) else $error("result not reduced");
`endif
endmodule
